>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: label");

// Antecedent implies consequent after the delay given by dly.
`define ASSERT_DELAY(label, ante, dly, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) \
		else $error("assertion failed: label");

`endif

>>> src/fcps_pkg.sv
// ----------------------------------------------------------------------------
// fcps_pkg
// Types and constants of the six-plane frustum point/sphere classifier.
// ----------------------------------------------------------------------------
package fcps_pkg;

	localparam int FIELD_BITS     = 21;
	localparam int RADIUS_BITS    = 20;
	localparam int REG_BITS       = 63;
	localparam int CFG_INDEX_BITS = 3;
	localparam int NUM_PLANES     = 6;
	// two register stages per cell plus the result register
	localparam int LATENCY        = 2 * NUM_PLANES + 1;

	// configuration register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_EYE    = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DIR    = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LEFT   = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RIGHT  = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TOP    = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_BOTTOM = 3'd5;
	localparam logic [CFG_INDEX_BITS-1:0] REG_NEAR   = 3'd6;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FAR    = 3'd7;

	// plane order along the chain: near, left, right, top, bottom, far
	localparam logic [CFG_INDEX_BITS-1:0] PLANE_ORIGIN [NUM_PLANES] =
		'{REG_NEAR, REG_EYE, REG_EYE, REG_EYE, REG_EYE, REG_FAR};
	localparam logic [CFG_INDEX_BITS-1:0] PLANE_DIR [NUM_PLANES] =
		'{REG_DIR, REG_LEFT, REG_RIGHT, REG_TOP, REG_BOTTOM, REG_DIR};

	// result codes
	localparam logic [1:0] REL_INSIDE    = 2'd0;
	localparam logic [1:0] REL_INTERSECT = 2'd1;
	localparam logic [1:0] REL_OUTSIDE   = 2'd2;

	typedef struct packed {
		logic valid;
		logic sphere;
		logic outside;
		logic inter;
	} cull_flags_t;

endpackage

>>> src/fcps_plane_cell.sv
// ----------------------------------------------------------------------------
// fcps_plane_cell
// One plane of the frustum: holds its origin and direction, forms the signed
// distance of the passing item and folds the plane verdict into its flags.
// ----------------------------------------------------------------------------
module fcps_plane_cell #(
	parameter int       W          = 21,
	parameter logic [2:0] ORIGIN_IDX = 3'd0,
	parameter logic [2:0] DIR_IDX    = 3'd1,
	parameter bit       FAR_PLANE  = 1'b0
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [fcps_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [fcps_pkg::REG_BITS-1:0]     cfg_data,
	input  fcps_pkg::cull_flags_t             in_flags,
	input  logic signed [W-1:0]               in_px,
	input  logic signed [W-1:0]               in_py,
	input  logic signed [W-1:0]               in_pz,
	input  logic [W-2:0]                      in_r,
	output fcps_pkg::cull_flags_t             out_flags,
	output logic signed [W-1:0]               out_px,
	output logic signed [W-1:0]               out_py,
	output logic signed [W-1:0]               out_pz,
	output logic [W-2:0]                      out_r
);
	import fcps_pkg::*;

	localparam int DW = W + 1;
	localparam int PW = 2 * W + 1;
	localparam int SW = 2 * W + 3;

	logic signed [W-1:0]  org_q [3];
	logic signed [W-1:0]  dir_q [3];
	logic signed [W-1:0]  p_in  [3];
	logic signed [DW-1:0] diff  [3];
	logic signed [PW-1:0] prod_d [3];

	logic signed [PW-1:0] prod_s1 [3];
	cull_flags_t          flags_s1;
	logic signed [W-1:0]  px_s1, py_s1, pz_s1;
	logic [W-2:0]         r_s1;

	logic signed [SW-1:0] pdist;
	logic signed [SW-1:0] rad;
	logic signed [SW-1:0] neg_rad;
	logic                 hit_out, hit_inter;

	cull_flags_t          flags_s2;
	logic signed [W-1:0]  px_s2, py_s2, pz_s2;
	logic [W-2:0]         r_s2;

	// plane geometry: user writes only while the block is idle; not enforced
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				org_q[k] <= '0;
				dir_q[k] <= '0;
			end
		end else if (cfg_we) begin
			for (int k = 0; k < 3; k++) begin
				if (cfg_index == ORIGIN_IDX)
					org_q[k] <= cfg_data[k*W +: W];
				if (cfg_index == DIR_IDX)
					dir_q[k] <= cfg_data[k*W +: W];
			end
		end
	end

	assign p_in[0] = in_px;
	assign p_in[1] = in_py;
	assign p_in[2] = in_pz;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			diff[k]   = DW'(p_in[k]) - DW'(org_q[k]);
			prod_d[k] = PW'(diff[k]) * PW'(dir_q[k]);
		end
	end

	// stage 1: component products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			flags_s1 <= '0;
		else
			flags_s1 <= in_flags;
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++)
			prod_s1[k] <= prod_d[k];
		px_s1 <= in_px;
		py_s1 <= in_py;
		pz_s1 <= in_pz;
		r_s1  <= in_r;
	end

	// stage 2: distance sum and plane verdict
	always_comb begin
		pdist   = SW'(prod_s1[0]) + SW'(prod_s1[1]) + SW'(prod_s1[2]);
		rad     = flags_s1.sphere ? signed'(SW'({r_s1, {(W-2){1'b0}}})) : '0;
		neg_rad = -rad;
		if (FAR_PLANE) begin
			// inside is on the negative side of the far plane
			hit_out   = pdist > rad;
			hit_inter = flags_s1.sphere ? (pdist > neg_rad) : (pdist == '0);
		end else begin
			hit_out   = pdist < neg_rad;
			hit_inter = flags_s1.sphere ? (pdist < rad) : (pdist == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_s2 <= '0;
		end else begin
			flags_s2.valid   <= flags_s1.valid;
			flags_s2.sphere  <= flags_s1.sphere;
			flags_s2.outside <= flags_s1.outside | hit_out;
			flags_s2.inter   <= flags_s1.inter | hit_inter;
		end
	end

	always_ff @(posedge clk) begin
		px_s2 <= px_s1;
		py_s2 <= py_s1;
		pz_s2 <= pz_s1;
		r_s2  <= r_s1;
	end

	assign out_flags = flags_s2;
	assign out_px    = px_s2;
	assign out_py    = py_s2;
	assign out_pz    = pz_s2;
	assign out_r     = r_s2;

endmodule

>>> src/frustum_cull_point_sphere_unit.sv
// ----------------------------------------------------------------------------
// frustum_cull_point_sphere_unit
// Six-plane view frustum classifier for points and bounding spheres.
// ----------------------------------------------------------------------------
// Usage:
//  - Configuration: cfg_valid/cfg_ready write channel, cfg_index selects one
//    of eight frustum registers, cfg_data carries the packed x,y,z value.
//    cfg_ready is always high; write only while no test is in flight.
//  - Command: a test is taken at a clock edge with start high and busy low.
//    kind selects point (0) or sphere (1); the centre and radius travel
//    with it.
//  - Result: relation (inside, intersecting, outside) shows for one cycle
//    with done high, once the test has passed the six plane cells into
//    the result register. The receiver cannot hold results off.
//  - Throughput: one test per cycle while busy is low. The item walks a
//    row of six plane cells (near, four sides, far), two register stages
//    each, plus the result register, which sets the latency.
//  - Reset: busy is high during reset and for the first cycle after it;
//    all in-flight tests are dropped and the frustum registers read zero.
// ----------------------------------------------------------------------------
module frustum_cull_point_sphere_unit #(
	parameter int COORD_BITS = 21
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 kind,
	input  logic signed [fcps_pkg::FIELD_BITS-1:0] point_x,
	input  logic signed [fcps_pkg::FIELD_BITS-1:0] point_y,
	input  logic signed [fcps_pkg::FIELD_BITS-1:0] point_z,
	input  logic [fcps_pkg::RADIUS_BITS-1:0]     sphere_radius,
	output logic                                 done,
	output logic [1:0]                           relation,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [fcps_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [fcps_pkg::REG_BITS-1:0]        cfg_data
);
	import fcps_pkg::*;

	localparam int W = COORD_BITS;

	cull_flags_t         chain_flags [NUM_PLANES+1];
	logic signed [W-1:0] chain_px    [NUM_PLANES+1];
	logic signed [W-1:0] chain_py    [NUM_PLANES+1];
	logic signed [W-1:0] chain_pz    [NUM_PLANES+1];
	logic [W-2:0]        chain_r     [NUM_PLANES+1];

	logic       busy_q;
	logic       cfg_we;
	logic       done_q;
	logic [1:0] rel_q;
	logic [1:0] rel_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			busy_q <= 1'b1;
		else
			busy_q <= 1'b0;
	end

	assign busy      = busy_q;
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid & cfg_ready;

	// head of the row: valid, sphere, outside, inter
	assign chain_flags[0] = cull_flags_t'({start & ~busy_q, kind, 2'b00});

	assign chain_px[0] = point_x[W-1:0];
	assign chain_py[0] = point_y[W-1:0];
	assign chain_pz[0] = point_z[W-1:0];
	assign chain_r[0]  = sphere_radius[W-2:0];

	for (genvar i = 0; i < NUM_PLANES; i++) begin : g_plane
		fcps_plane_cell #(
			.W          (W),
			.ORIGIN_IDX (PLANE_ORIGIN[i]),
			.DIR_IDX    (PLANE_DIR[i]),
			.FAR_PLANE  (i == NUM_PLANES - 1)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cfg_we    (cfg_we),
			.cfg_index (cfg_index),
			.cfg_data  (cfg_data),
			.in_flags  (chain_flags[i]),
			.in_px     (chain_px[i]),
			.in_py     (chain_py[i]),
			.in_pz     (chain_pz[i]),
			.in_r      (chain_r[i]),
			.out_flags (chain_flags[i+1]),
			.out_px    (chain_px[i+1]),
			.out_py    (chain_py[i+1]),
			.out_pz    (chain_pz[i+1]),
			.out_r     (chain_r[i+1])
		);
	end

	// outside on any plane wins over intersecting
	always_comb begin
		priority if (chain_flags[NUM_PLANES].outside)
			rel_d = REL_OUTSIDE;
		else if (chain_flags[NUM_PLANES].inter)
			rel_d = REL_INTERSECT;
		else
			rel_d = REL_INSIDE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= chain_flags[NUM_PLANES].valid;
	end

	always_ff @(posedge clk) begin
		rel_q <= rel_d;
	end

	assign done     = done_q;
	assign relation = rel_q;

endmodule

>>> src/fcps_checker.sv
// ----------------------------------------------------------------------------
// fcps_checker
// Port-level checks of the frustum classifier, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fcps_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [1:0] relation,
	input logic       cfg_valid,
	input logic       cfg_ready
);
	import fcps_pkg::*;

	// every start transfer yields a result after the fixed latency
	`ASSERT_DELAY(a_result_follows, start && !busy, LATENCY, done)
	// no result without a start transfer at the matching edge
	`ASSERT_IMPL(a_no_spurious, done, $past(start && !busy, LATENCY))
	// only the three defined result codes appear
	`ASSERT_IMPL(a_rel_code, done, relation <= REL_OUTSIDE)
	// configuration writes are never refused
	`ASSERT_IMPL(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind frustum_cull_point_sphere_unit fcps_checker u_fcps_checker (.*);

>>> bench/frustum_cull_point_sphere_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frustum_cull_point_sphere_unit_tb
// Self-checking bench for the six-plane frustum classifier. A directed table
// covers reset state, field extremes, on-plane points and zero-radius
// spheres. Random phases follow, each with its own frustum: a translated
// and scaled view volume, register extremes or random registers. Reset
// rows use table values; others a predictor in step with the registers.
// ----------------------------------------------------------------------------
module frustum_cull_point_sphere_unit_tb;
	import fcps_pkg::*;

	localparam logic KIND_POINT      = 1'b0;
	localparam logic KIND_SPHERE     = 1'b1;
	localparam int   NORM_FRAC       = FIELD_BITS - 2;
	localparam int   N_PHASES        = 12;
	localparam int   ITEMS_PER_PHASE = 110;
	localparam int   CYCLE_LIMIT     = 400000;
	localparam int   FIELD_MAX       = 1048575;
	localparam int   FIELD_MIN       = -1048576;
	localparam int   RADIUS_MAX      = 1048575;

	typedef enum {SETUP_KEEP, SETUP_VIEW} setup_t;
	typedef enum {SET_ONES, SET_MAX, SET_MIN, SET_RANDOM, SET_VIEW} frustum_set_t;

	typedef struct {
		setup_t     setup;
		logic       kind;
		int         px;
		int         py;
		int         pz;
		int         rad;
		bit         typed;
		logic [1:0] rel;
	} stim_row_t;

	localparam int N_DIRECTED = 21;

	// positions in Q12.8: 256 is one unit
	stim_row_t directed [N_DIRECTED] = '{
		// reset frustum: every distance is zero
		'{SETUP_KEEP, KIND_POINT,  0, 0, 0, 0, 1'b1, REL_INTERSECT},
		'{SETUP_KEEP, KIND_POINT,  FIELD_MAX, FIELD_MAX, FIELD_MAX, RADIUS_MAX, 1'b1,
			REL_INTERSECT},
		'{SETUP_KEEP, KIND_POINT,  FIELD_MIN, FIELD_MIN, FIELD_MIN, 0, 1'b1, REL_INTERSECT},
		'{SETUP_KEEP, KIND_SPHERE, 0, 0, 0, 0, 1'b1, REL_INSIDE},
		'{SETUP_KEEP, KIND_SPHERE, FIELD_MIN, FIELD_MAX, FIELD_MIN, RADIUS_MAX, 1'b1,
			REL_INTERSECT},
		'{SETUP_KEEP, KIND_SPHERE, FIELD_MAX, FIELD_MIN, FIELD_MAX, 1, 1'b1, REL_INTERSECT},
		// 90 degree view down +z, near at 1, far at 100
		'{SETUP_VIEW, KIND_POINT,  0, 0, 2560, 0, 1'b0, REL_INSIDE},
		'{SETUP_KEEP, KIND_POINT,  0, 0, 256, 0, 1'b0, REL_INSIDE},
		'{SETUP_KEEP, KIND_POINT,  0, 0, 25600, 0, 1'b0, REL_INSIDE},
		'{SETUP_KEEP, KIND_POINT,  0, 0, -1280, 0, 1'b0, REL_INSIDE},
		'{SETUP_KEEP, KIND_POINT,  0, 0, 51200, 0, 1'b0, REL_INSIDE},
		'{SETUP_KEEP, KIND_POINT,  -5120, 0, 2560, 0, 1'b0, REL_INSIDE},
		'{SETUP_KEEP, KIND_POINT,  -2560, 0, 2560, 0, 1'b0, REL_INSIDE},
		'{SETUP_KEEP, KIND_SPHERE, 0, 0, 2560, 256, 1'b0, REL_INSIDE},
		'{SETUP_KEEP, KIND_SPHERE, 0, 0, 384, 256, 1'b0, REL_INSIDE},
		'{SETUP_KEEP, KIND_SPHERE, 0, 0, 30720, 1280, 1'b0, REL_INSIDE},
		'{SETUP_KEEP, KIND_SPHERE, 0, 0, 256, 0, 1'b0, REL_INSIDE},
		'{SETUP_KEEP, KIND_SPHERE, -3072, 0, 2560, 768, 1'b0, REL_INSIDE},
		'{SETUP_KEEP, KIND_SPHERE, 0, 0, 0, RADIUS_MAX, 1'b0, REL_INSIDE},
		'{SETUP_KEEP, KIND_POINT,  FIELD_MAX, FIELD_MAX, FIELD_MAX, 0, 1'b0, REL_INSIDE},
		'{SETUP_KEEP, KIND_POINT,  FIELD_MIN, FIELD_MIN, FIELD_MIN, 0, 1'b0, REL_INSIDE}
	};

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	logic                         kind;
	logic signed [FIELD_BITS-1:0] point_x;
	logic signed [FIELD_BITS-1:0] point_y;
	logic signed [FIELD_BITS-1:0] point_z;
	logic [RADIUS_BITS-1:0]       sphere_radius;
	logic                         done;
	logic [1:0]                   relation;
	logic                         cfg_valid;
	logic                         cfg_ready;
	logic [CFG_INDEX_BITS-1:0]    cfg_index;
	logic [REG_BITS-1:0]          cfg_data;

	logic [REG_BITS-1:0] frustum [8];
	logic [1:0]          pending_relations [$];
	logic [1:0]          want;
	int                  mismatches = 0;
	int                  cycles = 0;

	// current view volume, used to aim random items
	int vex, vey, vez, vnz, vfz;

	frustum_cull_point_sphere_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.kind          (kind),
		.point_x       (point_x),
		.point_y       (point_y),
		.point_z       (point_z),
		.sphere_radius (sphere_radius),
		.done          (done),
		.relation      (relation),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycles);
			$display("FAIL frustum_cull_point_sphere_unit");
			$finish;
		end
	end

	function automatic logic [REG_BITS-1:0] pack3(input int a, input int b, input int c);
		logic [FIELD_BITS-1:0] fa, fb, fc;
		fa = a[FIELD_BITS-1:0];
		fb = b[FIELD_BITS-1:0];
		fc = c[FIELD_BITS-1:0];
		return {fc, fb, fa};
	endfunction

	function automatic longint comp(input logic [REG_BITS-1:0] r, input int k);
		logic signed [FIELD_BITS-1:0] c;
		c = r[k*FIELD_BITS +: FIELD_BITS];
		return longint'(c);
	endfunction

	function automatic longint plane_dist(input longint px, input longint py,
			input longint pz, input logic [REG_BITS-1:0] o, input logic [REG_BITS-1:0] dv);
		return (px - comp(o, 0)) * comp(dv, 0) + (py - comp(o, 1)) * comp(dv, 1)
			+ (pz - comp(o, 2)) * comp(dv, 2);
	endfunction

	function automatic logic [1:0] classify(input logic k, input logic signed [FIELD_BITS-1:0] x,
			input logic signed [FIELD_BITS-1:0] y, input logic signed [FIELD_BITS-1:0] z,
			input logic [RADIUS_BITS-1:0] rad);
		longint d [6];
		longint r, px, py, pz;
		bit     inter;
		px = longint'(x);
		py = longint'(y);
		pz = longint'(z);
		r = (k == KIND_SPHERE) ? (longint'(rad) << NORM_FRAC) : 64'sd0;
		// near and sides: positive is inside; far is negated to match
		d[0] = plane_dist(px, py, pz, frustum[REG_NEAR], frustum[REG_DIR]);
		d[1] = plane_dist(px, py, pz, frustum[REG_EYE], frustum[REG_LEFT]);
		d[2] = plane_dist(px, py, pz, frustum[REG_EYE], frustum[REG_RIGHT]);
		d[3] = plane_dist(px, py, pz, frustum[REG_EYE], frustum[REG_TOP]);
		d[4] = plane_dist(px, py, pz, frustum[REG_EYE], frustum[REG_BOTTOM]);
		d[5] = -plane_dist(px, py, pz, frustum[REG_FAR], frustum[REG_DIR]);
		inter = 1'b0;
		for (int i = 0; i < NUM_PLANES; i++) begin
			if (d[i] < -r)
				return REL_OUTSIDE;
			if ((k == KIND_SPHERE) ? (d[i] < r) : (d[i] == 0))
				inter = 1'b1;
		end
		return inter ? REL_INTERSECT : REL_INSIDE;
	endfunction

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_relations.size() == 0) begin
				$display("%0t: result with none expected, actual relation %0d", $time, relation);
				mismatches++;
			end else begin
				want = pending_relations.pop_front();
				if (relation !== want) begin
					$display("%0t: relation mismatch, expected %0d actual %0d",
						$time, want, relation);
					mismatches++;
				end
			end
		end
	end

	// called just after a rising edge; returns just after the accepting edge
	task automatic issue(input logic k, input int x, input int y, input int z, input int rad,
			input bit typed, input logic [1:0] rel);
		logic signed [FIELD_BITS-1:0] tx, ty, tz;
		logic [RADIUS_BITS-1:0]       tr;
		tx = x[FIELD_BITS-1:0];
		ty = y[FIELD_BITS-1:0];
		tz = z[FIELD_BITS-1:0];
		tr = rad[RADIUS_BITS-1:0];
		start         <= 1'b1;
		kind          <= k;
		point_x       <= tx;
		point_y       <= ty;
		point_z       <= tz;
		sphere_radius <= tr;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (typed)
			pending_relations.push_back(rel);
		else
			pending_relations.push_back(classify(k, tx, ty, tz, tr));
	endtask

	task automatic pause_sender(input int chance);
		if ($urandom_range(0, 99) < chance) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 11))
				@(posedge clk);
		end
	endtask

	// wait until every test in flight has come out
	task automatic settle();
		start <= 1'b0;
		while (pending_relations.size() != 0)
			@(posedge clk);
		repeat (LATENCY)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [REG_BITS-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		frustum[idx] = val;
	endtask

	task automatic load_frustum(input logic [REG_BITS-1:0] eye, input logic [REG_BITS-1:0] dir,
			input logic [REG_BITS-1:0] lft, input logic [REG_BITS-1:0] rgt,
			input logic [REG_BITS-1:0] top, input logic [REG_BITS-1:0] bot,
			input logic [REG_BITS-1:0] nr, input logic [REG_BITS-1:0] fr);
		write_reg(REG_EYE, eye);
		write_reg(REG_DIR, dir);
		write_reg(REG_LEFT, lft);
		write_reg(REG_RIGHT, rgt);
		write_reg(REG_TOP, top);
		write_reg(REG_BOTTOM, bot);
		write_reg(REG_NEAR, nr);
		write_reg(REG_FAR, fr);
		cfg_valid <= 1'b0;
	endtask

	// symmetric view down +z from the eye; s scales the side normals
	task automatic load_view(input int ex, input int ey, input int ez, input int s,
			input int dz, input int nz, input int fz);
		vex = ex;
		vey = ey;
		vez = ez;
		vnz = nz;
		vfz = fz;
		load_frustum(pack3(ex, ey, ez), pack3(0, 0, dz), pack3(s, 0, s), pack3(-s, 0, s),
			pack3(0, -s, s), pack3(0, s, s), pack3(ex, ey, ez + nz), pack3(ex, ey, ez + fz));
	endtask

	initial begin
		frustum_set_t setting;
		int           idle_chance, sel, ox, oy, oz, rad;
		logic         k;

		arst_n        <= 1'b0;
		start         <= 1'b0;
		kind          <= KIND_POINT;
		point_x       <= '0;
		point_y       <= '0;
		point_z       <= '0;
		sphere_radius <= '0;
		cfg_valid     <= 1'b0;
		cfg_index     <= REG_EYE;
		cfg_data      <= '0;
		for (int i = 0; i < 8; i++)
			frustum[i] = '0;
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;

		foreach (directed[i]) begin
			if (directed[i].setup == SETUP_VIEW) begin
				settle();
				load_view(0, 0, 0, 370728, 524288, 256, 25600);
			end
			issue(directed[i].kind, directed[i].px, directed[i].py, directed[i].pz,
				directed[i].rad, directed[i].typed, directed[i].rel);
			pause_sender(30);
		end

		for (int phase = 0; phase < N_PHASES; phase++) begin
			settle();
			if (phase == 0)
				setting = SET_ONES;
			else if (phase == 1)
				setting = SET_MAX;
			else if (phase == 2)
				setting = SET_MIN;
			else if (phase % 3 == 0)
				setting = SET_RANDOM;
			else
				setting = SET_VIEW;
			unique case (setting)
				SET_ONES: begin
					load_frustum('1, '1, '1, '1, '1, '1, '1, '1);
				end
				SET_MAX, SET_MIN: begin
					ox = (setting == SET_MAX) ? FIELD_MAX : FIELD_MIN;
					load_frustum(pack3(ox, ox, ox), pack3(ox, ox, ox), pack3(ox, ox, ox),
						pack3(ox, ox, ox), pack3(ox, ox, ox), pack3(ox, ox, ox),
						pack3(ox, ox, ox), pack3(ox, ox, ox));
				end
				SET_RANDOM: begin
					load_frustum(REG_BITS'({$urandom, $urandom}),
						REG_BITS'({$urandom, $urandom}),
						REG_BITS'({$urandom, $urandom}),
						REG_BITS'({$urandom, $urandom}),
						REG_BITS'({$urandom, $urandom}),
						REG_BITS'({$urandom, $urandom}),
						REG_BITS'({$urandom, $urandom}),
						REG_BITS'({$urandom, $urandom}));
				end
				default: begin
					oz = $urandom_range(0, 4096);
					load_view(int'($urandom_range(0, 524288)) - 262144,
						int'($urandom_range(0, 524288)) - 262144,
						int'($urandom_range(0, 524288)) - 262144,
						$urandom_range(1, FIELD_MAX), $urandom_range(1, FIELD_MAX), oz,
						$urandom_range(oz + 256, ($urandom_range(0, 1) == 0) ? 4096 : 131072));
				end
			endcase
			// last phase runs back to back
			if (phase == N_PHASES - 1 || $urandom_range(0, 3) == 0)
				idle_chance = 0;
			else
				idle_chance = $urandom_range(10, 60);

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				sel = $urandom_range(0, 19);
				k = 1'($urandom_range(0, 1));
				if (sel < 4) begin
					issue(k, $urandom, $urandom, $urandom, $urandom, 1'b0, REL_INSIDE);
				end else if (setting != SET_VIEW) begin
					rad = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 2048);
					issue(k, int'($urandom_range(0, 2048)) - 1024,
						int'($urandom_range(0, 2048)) - 1024,
						int'($urandom_range(0, 2048)) - 1024, rad, 1'b0, REL_INSIDE);
				end else begin
					oz = int'($urandom_range(0, vfz + vfz / 4)) - vfz / 8;
					ox = int'($urandom_range(0, 2 * vfz)) - vfz;
					oy = int'($urandom_range(0, 2 * vfz)) - vfz;
					// exactly on the left or right plane, or on the near plane
					if (sel == 4)
						ox = -oz;
					else if (sel == 5)
						ox = oz;
					else if (sel == 6) begin
						oz = vnz;
						ox = int'($urandom_range(0, 2 * vnz)) - vnz;
						oy = int'($urandom_range(0, 2 * vnz)) - vnz;
					end
					rad = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, vfz / 4);
					issue(k, vex + ox, vey + oy, vez + oz, rad, 1'b0, REL_INSIDE);
				end
				pause_sender(idle_chance);
			end
		end

		settle();
		repeat (4)
			@(posedge clk);
		if (pending_relations.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, pending_relations.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("PASS frustum_cull_point_sphere_unit");
		else
			$display("FAIL frustum_cull_point_sphere_unit");
		$finish;
	end

endmodule
